>>> rtl/gfppi_pkg.sv
// Shared types and constants for the GF(p) projective point index block.
package gfppi_pkg;

	localparam int IDX_BITS = 32;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_REDUCE,
		OP_PIVOT,
		OP_ALIGN,
		OP_DIV,
		OP_MULQ,
		OP_SWAP,
		OP_INV,
		OP_MUL,
		OP_PACK_MUL,
		OP_PACK_ADD,
		OP_ERROR,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_IN,
		C_CNT_NZ,
		C_P_LT2,
		C_ZERO_VEC,
		C_REM_NZ,
		C_GCD_BAD,
		C_OUT_BUSY
	} cond_t;

	typedef enum logic [1:0] {
		PV_X,
		PV_Y,
		PV_Z
	} pivot_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// status from the datapath that the sequencer branches on
	typedef struct packed {
		logic in_valid;
		logic cnt_nz;
		logic p_lt2;
		logic zero_vec;
		logic rem_nz;
		logic gcd_bad;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		op_t  op;
		logic idle;
	} ctl_t;

endpackage

>>> rtl/gfppi_seq.sv
// Microcode sequencer: step counter, control store and branch logic.
module gfppi_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  gfppi_pkg::flags_t flags,
	output gfppi_pkg::ctl_t   ctl
);

	localparam gfppi_pkg::step_t S_IDLE = 4'd0;
	localparam gfppi_pkg::step_t S_CHK  = 4'd1;
	localparam gfppi_pkg::step_t S_RED  = 4'd2;
	localparam gfppi_pkg::step_t S_PIV  = 4'd3;
	localparam gfppi_pkg::step_t S_ALN  = 4'd4;
	localparam gfppi_pkg::step_t S_DIV  = 4'd5;
	localparam gfppi_pkg::step_t S_MULQ = 4'd6;
	localparam gfppi_pkg::step_t S_SWP  = 4'd7;
	localparam gfppi_pkg::step_t S_GCD  = 4'd8;
	localparam gfppi_pkg::step_t S_INV  = 4'd9;
	localparam gfppi_pkg::step_t S_MUL  = 4'd10;
	localparam gfppi_pkg::step_t S_PK1  = 4'd11;
	localparam gfppi_pkg::step_t S_PK2  = 4'd12;
	localparam gfppi_pkg::step_t S_WAIT = 4'd13;
	localparam gfppi_pkg::step_t S_EMIT = 4'd14;
	localparam gfppi_pkg::step_t S_ERR  = 4'd15;

	gfppi_pkg::step_t  step_q;
	gfppi_pkg::step_t  step_nxt;
	gfppi_pkg::uword_t uw;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	// control store
	always_comb begin
		unique case (step_q)
			S_IDLE: uw = '{gfppi_pkg::OP_LOAD,     gfppi_pkg::C_NO_IN,    S_IDLE};
			S_CHK:  uw = '{gfppi_pkg::OP_NOP,      gfppi_pkg::C_P_LT2,    S_ERR};
			S_RED:  uw = '{gfppi_pkg::OP_REDUCE,   gfppi_pkg::C_CNT_NZ,   S_RED};
			S_PIV:  uw = '{gfppi_pkg::OP_PIVOT,    gfppi_pkg::C_ZERO_VEC, S_ERR};
			S_ALN:  uw = '{gfppi_pkg::OP_ALIGN,    gfppi_pkg::C_NEXT,     S_DIV};
			S_DIV:  uw = '{gfppi_pkg::OP_DIV,      gfppi_pkg::C_CNT_NZ,   S_DIV};
			S_MULQ: uw = '{gfppi_pkg::OP_MULQ,     gfppi_pkg::C_NEXT,     S_SWP};
			S_SWP:  uw = '{gfppi_pkg::OP_SWAP,     gfppi_pkg::C_REM_NZ,   S_ALN};
			S_GCD:  uw = '{gfppi_pkg::OP_NOP,      gfppi_pkg::C_GCD_BAD,  S_ERR};
			S_INV:  uw = '{gfppi_pkg::OP_INV,      gfppi_pkg::C_NEXT,     S_MUL};
			S_MUL:  uw = '{gfppi_pkg::OP_MUL,      gfppi_pkg::C_CNT_NZ,   S_MUL};
			S_PK1:  uw = '{gfppi_pkg::OP_PACK_MUL, gfppi_pkg::C_NEXT,     S_PK2};
			S_PK2:  uw = '{gfppi_pkg::OP_PACK_ADD, gfppi_pkg::C_NEXT,     S_WAIT};
			S_WAIT: uw = '{gfppi_pkg::OP_NOP,      gfppi_pkg::C_OUT_BUSY, S_WAIT};
			S_EMIT: uw = '{gfppi_pkg::OP_EMIT,     gfppi_pkg::C_ALWAYS,   S_IDLE};
			S_ERR:  uw = '{gfppi_pkg::OP_ERROR,    gfppi_pkg::C_ALWAYS,   S_WAIT};
		endcase
	end

	// branch condition select
	always_comb begin
		unique case (uw.cond)
			gfppi_pkg::C_NEXT:     take = 1'b0;
			gfppi_pkg::C_ALWAYS:   take = 1'b1;
			gfppi_pkg::C_NO_IN:    take = !flags.in_valid;
			gfppi_pkg::C_CNT_NZ:   take = flags.cnt_nz;
			gfppi_pkg::C_P_LT2:    take = flags.p_lt2;
			gfppi_pkg::C_ZERO_VEC: take = flags.zero_vec;
			gfppi_pkg::C_REM_NZ:   take = flags.rem_nz;
			gfppi_pkg::C_GCD_BAD:  take = flags.gcd_bad;
			gfppi_pkg::C_OUT_BUSY: take = flags.out_busy;
			default:               take = 1'b0;
		endcase
		step_nxt = take ? uw.target : step_q + 4'd1;
		ctl.op   = uw.op;
		ctl.idle = (step_q == S_IDLE);
	end

endmodule

>>> rtl/gfp_projective_point_index.sv
// Top level: projective point index over GF(p), microcoded datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_stall  | comp_x, comp_y, comp_z
//  output   | out_valid / out_stall| point_index, error
//  config   | cfg_we               | cfg_data (modulus p)
//
// One word at a time. The serial mod-p reduction, the shift-subtract divider of
// the Euclid loop and the serial modular multiply set how long a word takes;
// the divide of each Euclid step grows with the gap between the top bit positions
// of the two remainders. An error exit skips the rest of the program. Reset sets
// p to 2 and idles. A finished word waits in the output register; a new input
// word is taken while it waits, and only a second result stalls the program.
module gfp_projective_point_index #(
	parameter int COMP_BITS = 32,
	parameter int MOD_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [MOD_BITS-1:0]            cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [COMP_BITS-1:0]           comp_x,
	input  logic [COMP_BITS-1:0]           comp_y,
	input  logic [COMP_BITS-1:0]           comp_z,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gfppi_pkg::IDX_BITS-1:0] point_index,
	output logic                           error
);

	localparam int RW    = MOD_BITS + 1;
	localparam int TW    = MOD_BITS + 2;
	localparam int MAXB  = (COMP_BITS > MOD_BITS) ? COMP_BITS : MOD_BITS;
	localparam int CNT_W = $clog2(MAXB);
	localparam int IW    = gfppi_pkg::IDX_BITS;

	gfppi_pkg::flags_t flags;
	gfppi_pkg::ctl_t   ctl;

	logic [MOD_BITS-1:0]  modulus_q;
	logic [COMP_BITS-1:0] cx_q, cy_q, cz_q;
	logic [RW-1:0]        ra_q, rb_q, rc_q;
	logic [CNT_W-1:0]     cnt_q;
	gfppi_pkg::pivot_t    pv_q;
	logic [MOD_BITS-1:0]  r0_q, r1_q, rem_q, d_q, quo_q;
	logic signed [TW-1:0] t0_q, t1_q, mp_q;
	logic [MOD_BITS-1:0]  f_q, acca_q, accb_q;
	logic [IW-1:0]        prod_q;
	logic [IW-1:0]        res_index_q;
	logic                 res_error_q;
	logic [IW-1:0]        point_index_q;
	logic                 error_q;
	logic                 out_valid_q;

	logic [CNT_W-1:0]       shift;
	logic signed [TW-1:0]   tf;
	logic [2*MOD_BITS-1:0]  prod_full;
	logic                   in_take;
	logic                   out_take;

	// one restoring step of x mod p, feeding the next input bit
	function automatic logic [RW-1:0] red_step(input logic [RW-1:0] r, input logic b,
		input logic [MOD_BITS-1:0] p);
		logic [RW-1:0] v;
		v = {r[MOD_BITS-1:0], b};
		if (v >= {1'b0, p}) begin
			v = v - {1'b0, p};
		end
		return v;
	endfunction

	// acc = 2*acc + b*f mod p
	function automatic logic [MOD_BITS-1:0] mul_step(input logic [MOD_BITS-1:0] acc,
		input logic b, input logic [MOD_BITS-1:0] f, input logic [MOD_BITS-1:0] p);
		logic [RW-1:0] v;
		v = {acc, 1'b0};
		if (v >= {1'b0, p}) begin
			v = v - {1'b0, p};
		end
		if (b) begin
			v = v + {1'b0, f};
		end
		if (v >= {1'b0, p}) begin
			v = v - {1'b0, p};
		end
		return v[MOD_BITS-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] msb_pos(input logic [MOD_BITS-1:0] v);
		logic [CNT_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < MOD_BITS; i++) begin
			if (v[i]) begin
				pos = CNT_W'(i);
			end
		end
		return pos;
	endfunction

	gfppi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign in_stall = !ctl.idle;
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	always_comb begin
		flags.in_valid = in_valid;
		flags.cnt_nz   = (cnt_q != '0);
		flags.p_lt2    = (modulus_q < MOD_BITS'(2));
		flags.zero_vec = (ra_q == '0) && (rb_q == '0) && (rc_q == '0);
		flags.rem_nz   = (rem_q != '0);
		flags.gcd_bad  = (r0_q != MOD_BITS'(1));
		flags.out_busy = out_valid_q && out_stall;
	end

	always_comb begin
		shift = (msb_pos(r0_q) > msb_pos(r1_q)) ? msb_pos(r0_q) - msb_pos(r1_q) : '0;
		tf = t0_q[TW-1] ? t0_q + $signed(TW'(modulus_q)) : t0_q;
		if (tf >= $signed(TW'(modulus_q))) begin
			tf = tf - $signed(TW'(modulus_q));
		end
		prod_full = modulus_q * accb_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MOD_BITS'(2);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				modulus_q <= cfg_data;
			end
			if (ctl.op == gfppi_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			gfppi_pkg::OP_LOAD: begin
				cx_q  <= comp_x;
				cy_q  <= comp_y;
				cz_q  <= comp_z;
				ra_q  <= '0;
				rb_q  <= '0;
				rc_q  <= '0;
				cnt_q <= CNT_W'(COMP_BITS - 1);
			end
			gfppi_pkg::OP_REDUCE: begin
				ra_q  <= red_step(ra_q, cx_q[COMP_BITS-1], modulus_q);
				rb_q  <= red_step(rb_q, cy_q[COMP_BITS-1], modulus_q);
				rc_q  <= red_step(rc_q, cz_q[COMP_BITS-1], modulus_q);
				cx_q  <= cx_q << 1;
				cy_q  <= cy_q << 1;
				cz_q  <= cz_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			gfppi_pkg::OP_PIVOT: begin
				// last component that is non-zero mod p
				if (rc_q != '0) begin
					pv_q <= gfppi_pkg::PV_Z;
					r1_q <= rc_q[MOD_BITS-1:0];
				end else if (rb_q != '0) begin
					pv_q <= gfppi_pkg::PV_Y;
					r1_q <= rb_q[MOD_BITS-1:0];
				end else begin
					pv_q <= gfppi_pkg::PV_X;
					r1_q <= ra_q[MOD_BITS-1:0];
				end
				r0_q <= modulus_q;
				t0_q <= '0;
				t1_q <= TW'(1);
			end
			gfppi_pkg::OP_ALIGN: begin
				// line up the divisor's top bit with the dividend's
				rem_q <= r0_q;
				d_q   <= r1_q << shift;
				quo_q <= '0;
				cnt_q <= shift;
			end
			gfppi_pkg::OP_DIV: begin
				if (rem_q >= d_q) begin
					rem_q <= rem_q - d_q;
					quo_q <= {quo_q[MOD_BITS-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[MOD_BITS-2:0], 1'b0};
				end
				d_q   <= d_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			gfppi_pkg::OP_MULQ: begin
				mp_q <= $signed(TW'(quo_q)) * t1_q;
			end
			gfppi_pkg::OP_SWAP: begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= t0_q - mp_q;
			end
			gfppi_pkg::OP_INV: begin
				f_q    <= tf[MOD_BITS-1:0];
				acca_q <= '0;
				accb_q <= '0;
				cnt_q  <= CNT_W'(MOD_BITS - 1);
			end
			gfppi_pkg::OP_MUL: begin
				acca_q <= mul_step(acca_q, ra_q[MOD_BITS-1], f_q, modulus_q);
				accb_q <= mul_step(accb_q, rb_q[MOD_BITS-1], f_q, modulus_q);
				ra_q   <= ra_q << 1;
				rb_q   <= rb_q << 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			gfppi_pkg::OP_PACK_MUL: begin
				prod_q <= IW'(prod_full);
			end
			gfppi_pkg::OP_PACK_ADD: begin
				res_error_q <= 1'b0;
				case (pv_q)
					gfppi_pkg::PV_Z:
						res_index_q <= IW'(acca_q) + prod_q + IW'(modulus_q) + IW'(1);
					gfppi_pkg::PV_Y:
						res_index_q <= IW'(acca_q) + IW'(1);
					default:
						res_index_q <= '0;
				endcase
			end
			gfppi_pkg::OP_ERROR: begin
				res_error_q <= 1'b1;
				res_index_q <= '0;
			end
			gfppi_pkg::OP_EMIT: begin
				// move the finished word into the free output register
				point_index_q <= res_index_q;
				error_q       <= res_error_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign point_index = point_index_q;
	assign error       = error_q;

	// a result is only loaded into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == gfppi_pkg::OP_EMIT) |-> !(out_valid_q && out_stall))
		else $error("result emitted over a held word");

	// accepting a word starts the program
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !ctl.idle)
		else $error("sequencer stayed idle after accept");

	// the divider leaves a remainder below the divisor
	a_rem_lt_div: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == gfppi_pkg::OP_SWAP) |-> (rem_q < r1_q))
		else $error("Euclid remainder not reduced");

	// the inverse is only formed when the gcd is one
	a_inv_gcd: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == gfppi_pkg::OP_INV) |-> (r0_q == MOD_BITS'(1)))
		else $error("inverse formed with gcd not one");

	// an error word carries index zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && error_q) |-> (point_index_q == '0))
		else $error("error word with non-zero index");

endmodule
